/* design/drrlf_pkg.sv */
// Package for the DNS resource record length framer.
// Holds the transfer payload types, status codes and framing constants.
// No dependencies.
`default_nettype none

package drrlf_pkg;

    // Largest owner name accepted, in bytes, counting length bytes and root.
    localparam int DEF_MAX_NAME_BYTES = 255;

    // Widths of the stored counters.
    localparam int LEN_W   = 17;
    localparam int NAME_W  = 9;
    localparam int LABEL_W = 6;
    localparam int FIXED_W = 4;
    localparam int RDLEN_W = 16;

    // Fixed part after the owner name: type, class, TTL, rdata length.
    localparam logic [FIXED_W-1:0] FIXED_BYTES    = 4'd10;
    localparam logic [FIXED_W-1:0] RDLEN_POS_HIGH = 4'd2;
    localparam logic [7:0]         LABEL_TYPE_MASK = 8'hC0;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LABEL = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_LONG  = 2'd3;

    // One input byte of the record stream.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // One result: record length and status.
    typedef struct packed {
        logic [LEN_W-1:0] record_length;
        logic [1:0]       status;
    } t_out_item;

    // Result of one parser step, handed to the output register.
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

endpackage

`default_nettype wire

/* design/drrlf_parser.sv */
// Record walker for the DNS resource record length framer.
// Holds the per-record state and computes one step per byte.
// Depends on drrlf_pkg.
`default_nettype none

module drrlf_parser
    import drrlf_pkg::*;
#(
    parameter int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_in_item i_item,
    output t_result       o_result
);

    typedef enum logic [1:0] {
        PH_NAME  = 2'd0,
        PH_FIXED = 2'd1,
        PH_RDATA = 2'd2,
        PH_DRAIN = 2'd3
    } t_phase;

    localparam logic [NAME_W-1:0] NAME_LIMIT = NAME_W'(MAX_NAME_BYTES);

    t_phase               r_phase,   n_phase;
    logic [LABEL_W-1:0]   r_label,   n_label;
    logic [FIXED_W-1:0]   r_fixed,   n_fixed;
    logic [7:0]           r_rdhi,    n_rdhi;
    logic [RDLEN_W-1:0]   r_rdata,   n_rdata;
    logic [LEN_W-1:0]     r_rec_cnt, n_rec_cnt;
    logic [NAME_W-1:0]    r_name_cnt, n_name_cnt;

    // Next state and result for the byte being stepped.
    always_comb begin
        logic [LEN_W-1:0]   rec_inc;
        logic [NAME_W-1:0]  name_inc;
        logic [RDLEN_W-1:0] rdata_left;
        logic               too_long;
        logic               fail;
        logic [1:0]         fail_st;
        logic               done;
        logic               clear;

        rec_inc    = r_rec_cnt + 1'b1;
        name_inc   = r_name_cnt + 1'b1;
        too_long   = name_inc > NAME_LIMIT;
        rdata_left = r_rdata;
        fail       = 1'b0;
        fail_st    = ST_OK;
        done       = 1'b0;
        clear      = 1'b0;

        n_phase    = r_phase;
        n_label    = r_label;
        n_fixed    = r_fixed;
        n_rdhi     = r_rdhi;
        n_rdata    = r_rdata;
        n_rec_cnt  = r_rec_cnt;
        n_name_cnt = r_name_cnt;

        o_result.valid              = 1'b0;
        o_result.item.record_length = '0;
        o_result.item.status        = ST_OK;

        unique case (r_phase)
            PH_DRAIN: begin
                clear = i_item.last_byte;
            end
            PH_NAME: begin
                n_rec_cnt  = rec_inc;
                n_name_cnt = name_inc;
                if (r_label != '0) begin
                    n_label = r_label - 1'b1;
                    if (too_long) begin
                        fail    = 1'b1;
                        fail_st = ST_LONG;
                    end
                end else if (i_item.data_byte == 8'd0) begin
                    if (too_long) begin
                        fail    = 1'b1;
                        fail_st = ST_LONG;
                    end else begin
                        n_phase = PH_FIXED;
                        n_fixed = FIXED_BYTES;
                    end
                end else if ((i_item.data_byte & LABEL_TYPE_MASK) != 8'd0) begin
                    fail    = 1'b1;
                    fail_st = ST_LABEL;
                end else if (too_long) begin
                    fail    = 1'b1;
                    fail_st = ST_LONG;
                end else begin
                    n_label = i_item.data_byte[LABEL_W-1:0];
                end
            end
            PH_FIXED: begin
                n_rec_cnt = rec_inc;
                if (r_fixed == RDLEN_POS_HIGH) begin
                    n_rdhi = i_item.data_byte;
                end else if (r_fixed <= 4'd1) begin
                    rdata_left = {r_rdhi, i_item.data_byte};
                    n_rdata    = rdata_left;
                    if (rdata_left == '0) begin
                        done = 1'b1;
                    end else begin
                        n_phase = PH_RDATA;
                    end
                end
                if (r_fixed != '0) begin
                    n_fixed = r_fixed - 1'b1;
                end
            end
            PH_RDATA: begin
                n_rec_cnt = rec_inc;
                if (r_rdata != '0) begin
                    rdata_left = r_rdata - 1'b1;
                end
                n_rdata = rdata_left;
                done    = rdata_left == '0;
            end
            default: begin
                clear = 1'b1;
            end
        endcase

        // Result selection: an error wins, then completion, then truncation.
        if (r_phase != PH_DRAIN) begin
            if (fail) begin
                clear                = 1'b1;
                o_result.valid       = 1'b1;
                o_result.item.status = fail_st;
            end else if (done) begin
                clear                       = 1'b1;
                o_result.valid              = 1'b1;
                o_result.item.record_length = rec_inc;
            end else if (i_item.last_byte) begin
                clear                = 1'b1;
                o_result.valid       = 1'b1;
                o_result.item.status = ST_TRUNC;
            end
        end

        if (clear) begin
            n_phase    = (fail && !i_item.last_byte) ? PH_DRAIN : PH_NAME;
            n_label    = '0;
            n_fixed    = '0;
            n_rdhi     = '0;
            n_rdata    = '0;
            n_rec_cnt  = '0;
            n_name_cnt = '0;
        end

        if (!i_step) begin
            o_result.valid = 1'b0;
        end
    end

    // Record state, updated once per stepped byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_NAME;
            r_label    <= '0;
            r_fixed    <= '0;
            r_rdhi     <= '0;
            r_rdata    <= '0;
            r_rec_cnt  <= '0;
            r_name_cnt <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_label    <= n_label;
            r_fixed    <= n_fixed;
            r_rdhi     <= n_rdhi;
            r_rdata    <= n_rdata;
            r_rec_cnt  <= n_rec_cnt;
            r_name_cnt <= n_name_cnt;
        end
    end

endmodule

`default_nettype wire

/* design/dns_rr_length_framer.sv */
// A byte accepted into the input register is stepped by the parser and its result
// is held in the result register (two register stages: input, result).
// Throughput: one byte per cycle when not stalled, set by the record state update.
// Backpressure on the output stalls both stages; ready follows it combinationally.
// Reset (synchronous, active low) empties both stages and returns to the owner name.
// Depends on drrlf_pkg and drrlf_parser.
`default_nettype none

module dns_rr_length_framer
    import drrlf_pkg::*;
#(
    parameter int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;
    logic      step;
    t_result   result;

    // The pipeline moves whenever the result register is free or being drained.
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    drrlf_parser #(
        .MAX_NAME_BYTES(MAX_NAME_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in_item),
        .o_result(result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.valid) begin
            r_out_item <= result.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

/* design/drrlf_checker.sv */
// Port-level checker for the DNS resource record length framer, with its bind.
// Depends on drrlf_pkg and dns_rr_length_framer.
`default_nettype none

module drrlf_checker
    import drrlf_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    // The smallest complete record is a root name, ten fixed bytes, no rdata.
    a_ok_min_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_OK |-> o_out_item.record_length >= 17'd11)
        else $error("ok record shorter than the minimum record");

    // Every error result carries a zero length.
    a_err_zero_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.record_length == '0)
        else $error("error result with nonzero length");

    // No result right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    // A stalled result transfer keeps valid and payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

endmodule

bind dns_rr_length_framer drrlf_checker u_drrlf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_item (o_out_item)
);

`default_nettype wire
